// ===== hw/rtl/wshc_pkg.sv =====
package wshc_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 32;
    localparam int DimW = 16;

    // register indexes of the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        REG_MIN_SIZE     = 3'd0,
        REG_MAX_SIZE     = 3'd1,
        REG_BASE_SIZE    = 3'd2,
        REG_RESIZE_STEP  = 3'd3,
        REG_MIN_RATIO    = 3'd4,
        REG_MAX_RATIO    = 3'd5,
        REG_HINT_ENABLES = 3'd6
    } reg_idx_t;

    // hint_enables bits
    localparam int EN_MIN    = 0;
    localparam int EN_MAX    = 1;
    localparam int EN_ASPECT = 2;
    localparam int EN_STEP   = 3;
    localparam int EN_BASE   = 4;

    // pipeline stage numbers
    localparam int ST_CLAMP    = 0;
    localparam int ST_MUL_A    = 1;
    localparam int ST_SET_A    = 2;
    localparam int ST_DIV_A0   = 3;
    localparam int ST_DIV_A3   = 6;
    localparam int ST_WR_W     = 7;
    localparam int ST_MUL_B    = 8;
    localparam int ST_SET_B    = 9;
    localparam int ST_DIV_B0   = 10;
    localparam int ST_DIV_B3   = 13;
    localparam int ST_WR_H     = 14;
    localparam int ST_SNAP_SET = 15;
    localparam int ST_SNAP_D0  = 16;
    localparam int ST_SNAP_D3  = 19;
    localparam int ST_SNAP_MUL = 20;
    localparam int ST_SNAP_ADD = 21;
    localparam int NumStages   = 22;

    typedef struct packed {
        logic [DimW-1:0] req_width;
        logic [DimW-1:0] req_height;
    } req_t;

    typedef struct packed {
        logic [DimW-1:0] out_width;
        logic [DimW-1:0] out_height;
    } rsp_t;

    typedef struct packed {
        logic [31:0] min_size;
        logic [31:0] max_size;
        logic [31:0] base_size;
        logic [31:0] resize_step;
        logic [31:0] min_ratio;
        logic [31:0] max_ratio;
        logic [4:0]  hint_enables;
    } cfg_t;

    // restoring divider state: partial remainder and dividend/quotient shifter
    typedef struct packed {
        logic [DimW-1:0] rem;
        logic [DimW-1:0] quo;
    } div_t;

    typedef struct packed {
        logic [DimW-1:0] w;
        logic [DimW-1:0] h;
        logic [31:0]     pa;
        logic [31:0]     pb;
        logic            act_a;
        logic            sat_a;
        logic            act_b;
        div_t            da;
        div_t            db;
    } stage_t;

    // four quotient bits per call
    function automatic div_t div4(input div_t x, input logic [DimW-1:0] d);
        logic [DimW:0] t;
        div_t r;
        r = x;
        for (int k = 0; k < 4; k++) begin
            t = {r.rem, r.quo[DimW-1]};
            if (t >= {1'b0, d}) begin
                r.rem = DimW'(t - {1'b0, d});
                r.quo = {r.quo[DimW-2:0], 1'b1};
            end
            else begin
                r.rem = t[DimW-1:0];
                r.quo = {r.quo[DimW-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/window_size_hint_constrainer_top.sv =====
// Constrains a requested window size by min/max size, aspect ratio limits and
// resize step hints held in the configuration registers. The block is a
// 22-stage pipeline: one item enters per cycle unless the pipeline is stalled,
// and results leave in order from the last stage. The length is set by the
// 16-bit restoring dividers (minimum ratio, maximum ratio, and the paired
// width/height step snap), each section taking four stages at four quotient bits
// per stage. The whole pipeline advances together and holds while the output
// register waits. Write configuration only while no item is in flight.
module window_size_hint_constrainer_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  wshc_pkg::req_t          in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output wshc_pkg::rsp_t          out_data,
    input  logic                    cfg_we,
    input  logic [2:0]              cfg_index,
    input  logic [31:0]             cfg_data
);
    import wshc_pkg::*;

    cfg_t   cfg_reg;
    stage_t stage_reg  [NumStages];
    stage_t stage_next [NumStages];
    logic [NumStages-1:0] valid_reg;
    logic   adv;
    stage_t stage_in;

    function automatic stage_t stage_fn(input int idx, input stage_t s, input cfg_t c);
        stage_t r;
        logic [15:0] mw, mh, xw, xh, num1, den1, num2, den2, sw, sh, bw, bh;
        r    = s;
        mw   = c.min_size[15:0];
        mh   = c.min_size[31:16];
        xw   = c.max_size[15:0];
        xh   = c.max_size[31:16];
        num1 = c.min_ratio[15:0];
        den1 = c.min_ratio[31:16];
        num2 = c.max_ratio[15:0];
        den2 = c.max_ratio[31:16];
        sw   = c.resize_step[15:0];
        sh   = c.resize_step[31:16];
        bw   = c.hint_enables[EN_BASE] ? c.base_size[15:0] : mw;
        bh   = c.hint_enables[EN_BASE] ? c.base_size[31:16] : mh;
        case (idx) inside
            ST_CLAMP: begin
                if (c.hint_enables[EN_MIN]) begin
                    if (mw != '0 && r.w < mw) r.w = mw;
                    if (mh != '0 && r.h < mh) r.h = mh;
                end
                if (c.hint_enables[EN_MAX]) begin
                    if (xw != '0 && r.w > xw) r.w = xw;
                    if (xh != '0 && r.h > xh) r.h = xh;
                end
            end
            ST_MUL_A: begin
                r.pa = 32'(r.w) * 32'(den1);
                r.pb = 32'(r.h) * 32'(num1);
            end
            ST_SET_A: begin
                r.act_a = c.hint_enables[EN_ASPECT] && num1 != '0 && den1 != '0
                          && r.pa < r.pb;
                r.sat_a = r.pb >= {den1, 16'h0000};
                r.da    = '{rem: r.pb[31:16], quo: r.pb[15:0]};
            end
            [ST_DIV_A0:ST_DIV_A3]: r.da = div4(r.da, den1);
            ST_WR_W: begin
                if (r.act_a) r.w = r.sat_a ? 16'hFFFF : r.da.quo;
            end
            ST_MUL_B: begin
                r.pa = 32'(r.w) * 32'(den2);
                r.pb = 32'(r.h) * 32'(num2);
            end
            ST_SET_B: begin
                r.act_a = c.hint_enables[EN_ASPECT] && num2 != '0 && den2 != '0
                          && r.pa > r.pb;
                r.sat_a = r.pa >= {num2, 16'h0000};
                r.da    = '{rem: r.pa[31:16], quo: r.pa[15:0]};
            end
            [ST_DIV_B0:ST_DIV_B3]: r.da = div4(r.da, num2);
            ST_WR_H: begin
                if (r.act_a) r.h = r.sat_a ? 16'hFFFF : r.da.quo;
            end
            ST_SNAP_SET: begin
                r.act_a = c.hint_enables[EN_STEP] && sw > 16'd1 && r.w > bw;
                r.act_b = c.hint_enables[EN_STEP] && sh > 16'd1 && r.h > bh;
                r.da    = '{rem: '0, quo: 16'(r.w - bw)};
                r.db    = '{rem: '0, quo: 16'(r.h - bh)};
            end
            [ST_SNAP_D0:ST_SNAP_D3]: begin
                r.da = div4(r.da, sw);
                r.db = div4(r.db, sh);
            end
            ST_SNAP_MUL: begin
                r.pa = 32'(r.da.quo) * 32'(sw);
                r.pb = 32'(r.db.quo) * 32'(sh);
            end
            ST_SNAP_ADD: begin
                if (r.act_a) r.w = 16'(bw + r.pa[15:0]);
                if (r.act_b) r.h = 16'(bh + r.pb[15:0]);
            end
            default: r = s;
        endcase
        return r;
    endfunction

    // config registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                REG_MIN_SIZE:     cfg_reg.min_size     <= cfg_data;
                REG_MAX_SIZE:     cfg_reg.max_size     <= cfg_data;
                REG_BASE_SIZE:    cfg_reg.base_size    <= cfg_data;
                REG_RESIZE_STEP:  cfg_reg.resize_step  <= cfg_data;
                REG_MIN_RATIO:    cfg_reg.min_ratio    <= cfg_data;
                REG_MAX_RATIO:    cfg_reg.max_ratio    <= cfg_data;
                REG_HINT_ENABLES: cfg_reg.hint_enables <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless the output item is stuck
    assign adv      = !valid_reg[NumStages-1] || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        stage_in   = '0;
        stage_in.w = in_data.req_width;
        stage_in.h = in_data.req_height;
    end

    for (genvar i = 0; i < NumStages; i++) begin : g_stage
        if (i == 0) begin : g_first
            assign stage_next[i] = stage_fn(i, stage_in, cfg_reg);
        end
        else begin : g_rest
            assign stage_next[i] = stage_fn(i, stage_reg[i-1], cfg_reg);
        end

        always_ff @(posedge clk) begin
            if (adv) stage_reg[i] <= stage_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else if (adv) begin
            valid_reg <= {valid_reg[NumStages-2:0], in_valid};
        end
    end

    assign out_valid           = valid_reg[NumStages-1];
    assign out_data.out_width  = stage_reg[NumStages-1].w;
    assign out_data.out_height = stage_reg[NumStages-1].h;

`ifndef SYNTHESIS
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("pipeline stalled with output taken");

    a_div_a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_DIV_A0] && stage_reg[ST_DIV_A0].act_a && !stage_reg[ST_DIV_A0].sat_a
        |-> stage_reg[ST_DIV_A0].da.rem < cfg_reg.min_ratio[31:16])
        else $error("min ratio divider remainder out of range");

    a_div_b_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_DIV_B0] && stage_reg[ST_DIV_B0].act_a && !stage_reg[ST_DIV_B0].sat_a
        |-> stage_reg[ST_DIV_B0].da.rem < cfg_reg.max_ratio[15:0])
        else $error("max ratio divider remainder out of range");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("valid bits moved during stall");
`endif

endmodule
